>>> rtl/syn_cookie_halfsiphash_macros.svh
// Assertion macros for the SYN cookie hash block.
`ifndef SYN_COOKIE_HALFSIPHASH_MACROS_SVH
`define SYN_COOKIE_HALFSIPHASH_MACROS_SVH
`ifndef SYNTHESIS
// a implies b in the same cycle
`define SCH_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("sch assertion failed");
// a implies b in the next cycle
`define SCH_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("sch assertion failed");
// a implies b after the delay given by n
`define SCH_ASSERT_DELAY(lbl, clk, rst_n, a, n, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> ##n (b)) \
        else $error("sch assertion failed");
`else
`define SCH_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define SCH_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`define SCH_ASSERT_DELAY(lbl, clk, rst_n, a, n, b)
`endif
`endif

>>> rtl/sch_pkg.sv
// Types, constants and the mixing round shared by the SYN cookie hash block.
`default_nettype none
package sch_pkg;

    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int N_MSG_WORDS = 4;
    localparam int N_CROUNDS  = 2;
    localparam int N_DROUNDS  = 4;
    localparam int N_CELLS    = N_MSG_WORDS * N_CROUNDS + N_DROUNDS;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 4'd1;

    localparam logic [WORD_W-1:0] KEY_LOW_RESET  = 32'h3332_3130;
    localparam logic [WORD_W-1:0] KEY_HIGH_RESET = 32'h4241_3938;

    localparam logic [WORD_W-1:0] IV0 = 32'h7073_6575;
    localparam logic [WORD_W-1:0] IV1 = 32'h6e64_6f6d;
    localparam logic [WORD_W-1:0] IV2 = 32'h6e65_7261;
    localparam logic [WORD_W-1:0] IV3 = 32'h7974_6573;

    typedef logic [3:0][WORD_W-1:0] t_vec;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port_num;
        logic [15:0] dest_port_num;
        logic [31:0] client_sequence;
        logic [63:0] time_now_ns;
    } t_item;

    typedef struct packed {
        logic [31:0] cookie_value;
        logic [31:0] epoch_value;
    } t_result;

    // Data handed from one cell to the next
    typedef struct packed {
        t_vec              v;
        t_vec              w;
        logic [WORD_W-1:0] epoch;
    } t_stage;

    function automatic logic [WORD_W-1:0] rol32(input logic [WORD_W-1:0] x, input int s);
        rol32 = (x << s) | (x >> (WORD_W - s));
    endfunction

    function automatic t_vec mix_round(input t_vec s_in);
        t_vec s;
        s = s_in;
        s[0] = s[0] + s[1];
        s[2] = s[2] + s[3];
        s[1] = rol32(s[1], 5);
        s[3] = rol32(s[3], 8);
        s[1] = s[1] ^ s[0];
        s[3] = s[3] ^ s[2];
        s[0] = rol32(s[0], 16);
        s[2] = s[2] + s[1];
        s[0] = s[0] + s[3];
        s[1] = rol32(s[1], 13);
        s[3] = rol32(s[3], 7);
        s[1] = s[1] ^ s[2];
        s[3] = s[3] ^ s[0];
        s[2] = rol32(s[2], 16);
        mix_round = s;
    endfunction

endpackage
`default_nettype wire

>>> rtl/syn_cookie_halfsiphash.sv
// Top level: SYN cookie generator built on a row of HalfSipHash-2-4 round cells.
//
// One connection item is taken in every cycle in which start is high; busy is
// always low. Each item passes through twelve round cells, one round per cell
// per cycle (eight compression rounds over the four packed words, then four
// finalization rounds), then through one output register; its cookie is marked
// by a one-cycle o_valid strobe, in acceptance order. The receiver cannot stall
// the block: a result not taken in its strobe cycle is gone. The key registers
// are sampled as an item enters, so write them only while no item is in flight.
`default_nettype none
`include "syn_cookie_halfsiphash_macros.svh"
module syn_cookie_halfsiphash #(
    parameter int EPOCH_SHIFT = 28
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire sch_pkg::t_item                i_item,
    input  wire logic                          i_cfg_we,
    input  wire logic [sch_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sch_pkg::WORD_W-1:0]    i_cfg_data,
    output logic                               o_valid,
    output sch_pkg::t_result                   o_result
);

    localparam int LATENCY = sch_pkg::N_CELLS + 1;

    logic [sch_pkg::WORD_W-1:0] r_key_low;
    logic [sch_pkg::WORD_W-1:0] r_key_high;
    logic                       r_out_valid;
    sch_pkg::t_result           r_result;
    sch_pkg::t_result           n_result;
    logic [sch_pkg::WORD_W-1:0] w_epoch;
    logic                       w_accept;
    sch_pkg::t_stage            w_first;

    logic            w_valid [sch_pkg::N_CELLS+1];
    sch_pkg::t_stage w_stage [sch_pkg::N_CELLS+1];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_epoch  = 32'(i_item.time_now_ns >> EPOCH_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= sch_pkg::KEY_LOW_RESET;
            r_key_high <= sch_pkg::KEY_HIGH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sch_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                sch_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Load the initial state and the packed words into the first cell
    always_comb begin
        w_first.v[0]    = r_key_low ^ sch_pkg::IV0;
        w_first.v[1]    = r_key_high ^ sch_pkg::IV1;
        w_first.v[2]    = r_key_low ^ sch_pkg::IV2;
        w_first.v[3]    = r_key_high ^ sch_pkg::IV3;
        w_first.w[0]    = i_item.source_address;
        w_first.w[1]    = i_item.dest_address;
        w_first.w[2]    = {i_item.source_port_num, i_item.dest_port_num};
        w_first.w[3]    = i_item.client_sequence;
        w_first.epoch   = w_epoch;
    end

    assign w_valid[0] = w_accept;
    assign w_stage[0] = w_first;

    for (genvar g = 0; g < sch_pkg::N_CELLS; g++) begin : g_cell
        localparam bit IN_MSG = g < sch_pkg::N_MSG_WORDS * sch_pkg::N_CROUNDS;
        sch_round_cell #(
            .PRE_XOR  (IN_MSG && (g % sch_pkg::N_CROUNDS == 0)),
            .POST_XOR (IN_MSG && (g % sch_pkg::N_CROUNDS == sch_pkg::N_CROUNDS - 1)),
            .WORD_IDX (IN_MSG ? g / sch_pkg::N_CROUNDS : 0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_stage (w_stage[g]),
            .o_valid (w_valid[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    always_comb begin
        n_result.epoch_value  = w_stage[sch_pkg::N_CELLS].epoch;
        n_result.cookie_value = w_stage[sch_pkg::N_CELLS].epoch
                              ^ w_stage[sch_pkg::N_CELLS].v[0]
                              ^ w_stage[sch_pkg::N_CELLS].v[1]
                              ^ w_stage[sch_pkg::N_CELLS].v[2]
                              ^ w_stage[sch_pkg::N_CELLS].v[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_valid[sch_pkg::N_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    `SCH_ASSERT_DELAY(a_accept_to_result, i_clk, i_rst_n, w_accept, LATENCY, o_valid)
    `SCH_ASSERT_IMP(a_result_has_item, i_clk, i_rst_n, o_valid, $past(w_accept, LATENCY))
    `SCH_ASSERT_IMP(a_epoch_follows, i_clk, i_rst_n, o_valid,
        o_result.epoch_value == $past(w_epoch, LATENCY))
    `SCH_ASSERT_NEXT(a_key_low_write, i_clk, i_rst_n,
        i_cfg_we && (i_cfg_idx == sch_pkg::CFG_KEY_LOW), r_key_low == $past(i_cfg_data))

endmodule
`default_nettype wire

>>> rtl/sch_round_cell.sv
// One HalfSipHash round cell with optional message-word injection.
`default_nettype none
module sch_round_cell #(
    parameter bit PRE_XOR  = 1'b0,
    parameter bit POST_XOR = 1'b0,
    parameter int WORD_IDX = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire sch_pkg::t_stage i_stage,
    output logic                o_valid,
    output sch_pkg::t_stage     o_stage
);

    localparam logic [1:0] WSEL = 2'(WORD_IDX);

    logic            r_valid;
    sch_pkg::t_stage r_stage;
    sch_pkg::t_stage n_stage;
    sch_pkg::t_vec   w_pre;
    sch_pkg::t_vec   w_mix;

    always_comb begin
        w_pre = i_stage.v;
        if (PRE_XOR) begin
            w_pre[3] = w_pre[3] ^ i_stage.w[WSEL];
        end
        w_mix = sch_pkg::mix_round(w_pre);
        if (POST_XOR) begin
            w_mix[0] = w_mix[0] ^ i_stage.w[WSEL];
        end
        n_stage       = i_stage;
        n_stage.v     = w_mix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload advances every cycle; no reset needed
    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
`default_nettype wire

>>> test/syn_cookie_halfsiphash_test.sv
// Self-checking testbench for the SYN cookie HalfSipHash-2-4 generator.
`timescale 1ns / 1ps
module syn_cookie_halfsiphash_test;

    localparam int EPOCH_SHIFT    = 28;
    localparam int RESULT_LATENCY = 13;
    localparam int STALL_LIMIT    = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int IDX_W          = sch_pkg::CFG_IDX_W;
    localparam logic [sch_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

    typedef logic [3:0][31:0] t_sip_state;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          start      = 1'b0;
    logic                          busy;
    sch_pkg::t_item                i_item     = '0;
    logic                          i_cfg_we   = 1'b0;
    logic [sch_pkg::CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [sch_pkg::WORD_W-1:0]    i_cfg_data = '0;
    logic                          o_valid;
    sch_pkg::t_result              o_result;

    sch_pkg::t_item   pending_items[$];
    sch_pkg::t_result cookies_due[$];
    logic [31:0]      key_low       = sch_pkg::KEY_LOW_RESET;
    logic [31:0]      key_high      = sch_pkg::KEY_HIGH_RESET;
    int               send_idle_pct = 0;
    int               items_sent    = 0;
    int               cookies_seen  = 0;
    int               errors        = 0;
    int               stall_cycles  = 0;

    syn_cookie_halfsiphash #(
        .EPOCH_SHIFT(EPOCH_SHIFT)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic t_sip_state sip_round(input t_sip_state st);
        t_sip_state s;
        s = st;
        s[0] = s[0] + s[1];
        s[2] = s[2] + s[3];
        s[1] = rotl(s[1], 5);
        s[3] = rotl(s[3], 8);
        s[1] = s[1] ^ s[0];
        s[3] = s[3] ^ s[2];
        s[0] = rotl(s[0], 16);
        s[2] = s[2] + s[1];
        s[0] = s[0] + s[3];
        s[1] = rotl(s[1], 13);
        s[3] = rotl(s[3], 7);
        s[1] = s[1] ^ s[2];
        s[3] = s[3] ^ s[0];
        s[2] = rotl(s[2], 16);
        return s;
    endfunction

    function automatic sch_pkg::t_result cookie_of(input sch_pkg::t_item it,
                                                   input logic [31:0] klo,
                                                   input logic [31:0] khi);
        t_sip_state       s;
        logic [31:0]      words[4];
        logic [63:0]      shifted;
        logic [31:0]      digest;
        sch_pkg::t_result res;
        words[0] = it.source_address;
        words[1] = it.dest_address;
        words[2] = {it.source_port_num, it.dest_port_num};
        words[3] = it.client_sequence;
        s[0] = klo ^ sch_pkg::IV0;
        s[1] = khi ^ sch_pkg::IV1;
        s[2] = klo ^ sch_pkg::IV2;
        s[3] = khi ^ sch_pkg::IV3;
        for (int k = 0; k < 4; k++) begin
            s[3] = s[3] ^ words[k];
            s = sip_round(sip_round(s));
            s[0] = s[0] ^ words[k];
        end
        for (int k = 0; k < 4; k++) begin
            s = sip_round(s);
        end
        digest = s[0] ^ s[1] ^ s[2] ^ s[3];
        shifted = it.time_now_ns >> EPOCH_SHIFT;
        res.epoch_value  = shifted[31:0];
        res.cookie_value = shifted[31:0] ^ digest;
        return res;
    endfunction

    // Bias toward all-zero and all-one fields.
    function automatic logic [63:0] field_value(input int width);
        logic [63:0] mask;
        mask = (64'd1 << width) - 64'd1;
        case ($urandom_range(7))
            0: return '0;
            1: return mask;
            default: return {$urandom, $urandom} & mask;
        endcase
    endfunction

    function automatic sch_pkg::t_item rand_item();
        sch_pkg::t_item it;
        it.source_address  = 32'(field_value(32));
        it.dest_address    = 32'(field_value(32));
        it.source_port_num = 16'(field_value(16));
        it.dest_port_num   = 16'(field_value(16));
        it.client_sequence = 32'(field_value(32));
        it.time_now_ns     = field_value(64);
        return it;
    endfunction

    task automatic write_reg(input logic [sch_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == sch_pkg::CFG_KEY_LOW) begin
            key_low = data;
        end else if (idx == sch_pkg::CFG_KEY_HIGH) begin
            key_high = data;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || start || cookies_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_items(input int count, input int idle_pct);
        @(negedge i_clk);
        send_idle_pct = idle_pct;
        repeat (count) pending_items = {pending_items, rand_item()};
        drain();
    endtask

    // Driver: present queued items, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                cookies_due = {cookies_due, cookie_of(i_item, key_low, key_high)};
                items_sent++;
            end
            if (!(start && busy)) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    start  <= 1'b1;
                    i_item <= pending_items.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each strobed cookie with the oldest one due.
    always @(posedge i_clk) begin
        sch_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            cookies_seen++;
            if (cookies_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("unexpected cookie %h epoch %h",
                             o_result.cookie_value, o_result.epoch_value);
                end
            end else begin
                want = cookies_due.pop_front();
                if (o_result.cookie_value !== want.cookie_value ||
                    o_result.epoch_value !== want.epoch_value) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $display("mismatch: want cookie %h epoch %h, got cookie %h epoch %h",
                                 want.cookie_value, want.epoch_value,
                                 o_result.cookie_value, o_result.epoch_value);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no item or cookie for %0d cycles", STALL_LIMIT);
                $display("syn_cookie_halfsiphash_test: errors");
                $finish;
            end
        end
    end

    initial begin
        sch_pkg::t_item it;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset key.
        @(negedge i_clk);
        send_idle_pct = 23;
        for (int n = 0; n < 16; n++) begin
            it = '0;
            case (n)
                1: it = '1;
                2: it.source_address = '1;
                3: it.dest_address = '1;
                4: it.source_port_num = '1;
                5: it.dest_port_num = '1;
                6: it.client_sequence = '1;
                7: it.time_now_ns = '1;
                8: it.time_now_ns = (64'd1 << EPOCH_SHIFT) - 64'd1;
                9: it.time_now_ns = 64'd1 << EPOCH_SHIFT;
                // epoch bits above 32 are dropped
                10: it.time_now_ns = 64'd1 << (EPOCH_SHIFT + 32);
                11: it.time_now_ns = 64'd1 << (EPOCH_SHIFT + 31);
                12: begin
                    it.source_port_num = 16'h8000;
                    it.dest_port_num   = 16'h0001;
                end
                13: begin
                    it.source_port_num = 16'h0001;
                    it.dest_port_num   = 16'h8000;
                end
                14: begin
                    it.source_address  = 32'h8000_0001;
                    it.dest_address    = 32'h0000_0001;
                    it.client_sequence = 32'h8000_0000;
                end
                15: it = rand_item();
                default: it = '0;
            endcase
            pending_items = {pending_items, it};
        end
        run_items(150, 23);

        write_reg(sch_pkg::CFG_KEY_LOW, '0);
        write_reg(sch_pkg::CFG_KEY_HIGH, '0);
        run_items(120, 23);

        write_reg(sch_pkg::CFG_KEY_LOW, '1);
        write_reg(sch_pkg::CFG_KEY_HIGH, '1);
        run_items(120, 81);

        // Writes to unused indexes must leave the key alone.
        write_reg(sch_pkg::CFG_KEY_LOW, $urandom);
        write_reg(sch_pkg::CFG_KEY_HIGH, $urandom);
        write_reg(IDX_W'($urandom_range(CFG_IDX_TOP, sch_pkg::CFG_KEY_HIGH + 1)), $urandom);
        write_reg(CFG_IDX_TOP, $urandom);
        run_items(220, 81);

        write_reg(sch_pkg::CFG_KEY_HIGH, $urandom);
        write_reg(sch_pkg::CFG_KEY_LOW, $urandom);
        run_items(220, 0);

        repeat (2 * RESULT_LATENCY) @(posedge i_clk);
        $display("%0d connection items hashed, %0d cookies compared, %0d errors",
                 items_sent, cookies_seen, errors);
        $display("keys: reset, all-zero, all-one, two random; sender gaps 23%%, 81%%, none");
        if (errors == 0) begin
            $display("syn_cookie_halfsiphash_test: clean");
        end else begin
            $display("syn_cookie_halfsiphash_test: errors");
        end
        $finish;
    end

endmodule
